// File: src/ahet_pkg.sv
// Shared types, constants and defaults for the access hazard edge tracker.
`timescale 1ns / 1ps
package ahet_pkg;

  // Default sizing of the tracker
  localparam int RESOURCES_DEF      = 64;
  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int STATEMENT_BITS_DEF = 16;

  // Fixed field widths of the channels
  localparam int STMT_W = 16;
  localparam int RES_W  = 6;

  // Access kind as stored with each queued entry
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FRONT,
    ST_DRAIN,
    ST_FINISH
  } ahet_state_t;

  // Which result the output register is loaded with
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_OVF,
    EMIT_FRONT,
    EMIT_PEND_MID,
    EMIT_PEND_LAST
  } ahet_emit_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load;
    logic       rd_first;
    logic       rd_next;
    logic       push_read;
    logic       put_write;
    logic       pend_load;
    logic       pend_clr;
    ahet_emit_t emit;
  } ahet_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_range;
    logic is_write;
    logic cnt_full;
    logic cnt_zero;
    logic front_wr;
    logic front_same;
    logic ent_same;
    logic more;
    logic pend_v;
    logic out_free;
  } ahet_stat_t;

endpackage

// File: src/ahet_ifs.sv
// Valid/ready channel interfaces for access items and edge results.
`timescale 1ns / 1ps
interface ahet_in_if
  import ahet_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STMT_W-1:0] statement_id;
  logic [RES_W-1:0]  resource_index;
  logic              is_write;

  modport source (output valid, output statement_id, output resource_index,
                  output is_write, input ready);
  modport sink   (input valid, input statement_id, input resource_index,
                  input is_write, output ready);
endinterface

interface ahet_out_if
  import ahet_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STMT_W-1:0] edge_source;
  logic [STMT_W-1:0] edge_target;
  logic              last_of_run;
  logic              queue_overflow;

  modport source (output valid, output edge_source, output edge_target,
                  output last_of_run, output queue_overflow, input ready);
  modport sink   (input valid, input edge_source, input edge_target,
                  input last_of_run, input queue_overflow, output ready);
endinterface

// File: src/ahet_ctrl.sv
// Controller state machine sequencing lookup, push, drain and emit steps.
`timescale 1ns / 1ps
module ahet_ctrl
  import ahet_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ahet_stat_t stat,
  output ahet_cmd_t  cmd
);

  ahet_state_t state_r, state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit  = EMIT_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!stat.in_range) begin
          state_nxt = ST_IDLE;
        end else if (!stat.is_write) begin
          if (stat.cnt_full) begin
            // drop the read, report overflow once
            if (stat.out_free) begin
              cmd.emit  = EMIT_OVF;
              state_nxt = ST_IDLE;
            end
          end else if (stat.cnt_zero) begin
            cmd.push_read = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            cmd.rd_first = 1'b1;
            state_nxt    = ST_FRONT;
          end
        end else begin
          if (stat.cnt_zero) begin
            cmd.put_write = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            cmd.rd_first = 1'b1;
            cmd.pend_clr = 1'b1;
            state_nxt    = ST_DRAIN;
          end
        end
      end
      ST_FRONT: begin
        if (stat.front_wr && stat.front_same) begin
          state_nxt = ST_IDLE;
        end else if (stat.front_wr) begin
          if (stat.out_free) begin
            cmd.emit      = EMIT_FRONT;
            cmd.push_read = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          cmd.push_read = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        // keep one edge in hand so the final one can be flagged last
        if (!(!stat.ent_same && stat.pend_v && !stat.out_free)) begin
          if (!stat.ent_same) begin
            cmd.pend_load = 1'b1;
            if (stat.pend_v) begin
              cmd.emit = EMIT_PEND_MID;
            end
          end
          if (stat.more) begin
            cmd.rd_next = 1'b1;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (stat.pend_v) begin
          if (stat.out_free) begin
            cmd.emit      = EMIT_PEND_LAST;
            cmd.put_write = 1'b1;
            cmd.pend_clr  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          cmd.put_write = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/ahet_dpath.sv
// Datapath: item registers, queue memory, per-resource counts and result register.
`timescale 1ns / 1ps
module ahet_dpath
  import ahet_pkg::*;
#(
  parameter int RESOURCES      = RESOURCES_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int STATEMENT_BITS = STATEMENT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [STMT_W-1:0] in_statement_id,
  input  logic [RES_W-1:0]  in_resource_index,
  input  logic              in_is_write,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STMT_W-1:0] out_edge_source,
  output logic [STMT_W-1:0] out_edge_target,
  output logic              out_last_of_run,
  output logic              out_queue_overflow,
  input  ahet_cmd_t         cmd,
  output ahet_stat_t        stat
);

  localparam int NRES      = (RESOURCES > (1 << RES_W)) ? (1 << RES_W) : RESOURCES;
  localparam int RW        = $clog2(NRES);
  localparam int QW        = $clog2(QUEUE_DEPTH);
  localparam int CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int SW        = (STATEMENT_BITS < STMT_W) ? STATEMENT_BITS : STMT_W;
  localparam int NSLOT     = 1 << RW;
  localparam int MEM_DEPTH = 1 << (RW + QW);

  // Item registers
  logic [SW-1:0] stmt_r;
  logic [RW-1:0] res_r;
  logic          wr_r;
  logic          in_range_r;
  logic [CW-1:0] idx_r;

  // Queue memory: {kind, statement} per entry
  logic [SW:0]      qmem [MEM_DEPTH];
  logic [SW:0]      rd_q;
  logic             mem_we;
  logic [RW+QW-1:0] mem_wa;
  logic [SW:0]      mem_wd;
  logic             mem_re;
  logic [RW+QW-1:0] mem_ra;

  // Per-resource fill counts; a count reads as zero until first written
  logic [CW-1:0]    cnt_arr [NSLOT];
  logic [NSLOT-1:0] cnt_seen_r;
  logic [CW-1:0]    cnt_rd_r;
  logic             cnt_hit_r;
  logic [CW-1:0]    cnt_cur;

  // Edge held back during a drain
  logic          pend_v_r;
  logic [SW-1:0] pend_r;

  // Result register
  logic              out_valid_r;
  logic [STMT_W-1:0] src_r;
  logic [STMT_W-1:0] dst_r;
  logic              last_r;
  logic              ovf_r;
  logic              out_free;

  assign out_free = !out_valid_r || out_ready;

  // Latch the accepted item and its queue's fill count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stmt_r     <= in_statement_id[SW-1:0];
      res_r      <= in_resource_index[RW-1:0];
      wr_r       <= in_is_write;
      in_range_r <= (32'(in_resource_index) < RESOURCES);
      cnt_rd_r   <= cnt_arr[in_resource_index[RW-1:0]];
      cnt_hit_r  <= cnt_seen_r[in_resource_index[RW-1:0]];
    end
  end

  assign cnt_cur = cnt_hit_r ? cnt_rd_r : '0;

  // Advance the drain read index
  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      idx_r <= CW'(1);
    end else if (cmd.rd_next) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  // Memory port selection
  always_comb begin
    mem_re = cmd.rd_first || cmd.rd_next;
    mem_ra = {res_r, (cmd.rd_next ? idx_r[QW-1:0] : QW'(0))};
    mem_we = cmd.push_read || cmd.put_write;
    mem_wa = {res_r, (cmd.put_write ? QW'(0) : cnt_cur[QW-1:0])};
    mem_wd = {(cmd.put_write ? KIND_WRITE : KIND_READ), stmt_r};
  end

  // Write the queue memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      qmem[mem_wa] <= mem_wd;
    end
  end

  // Read the queue memory; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_q <= qmem[mem_ra];
    end
  end

  // Update fill counts
  always_ff @(posedge clk) begin
    if (cmd.put_write) begin
      cnt_arr[res_r] <= CW'(1);
    end else if (cmd.push_read) begin
      cnt_arr[res_r] <= cnt_cur + CW'(1);
    end
  end

  // Mark the counts written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_seen_r <= '0;
    end else if (cmd.put_write || cmd.push_read) begin
      cnt_seen_r[res_r] <= 1'b1;
    end
  end

  // Hold the latest edge found in a drain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (cmd.pend_load) begin
      pend_v_r <= 1'b1;
    end else if (cmd.pend_clr) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend_r <= rd_q[SW-1:0];
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_OVF: begin
        src_r  <= '0;
        dst_r  <= STMT_W'(stmt_r);
        last_r <= 1'b1;
        ovf_r  <= 1'b1;
      end
      EMIT_FRONT: begin
        src_r  <= STMT_W'(rd_q[SW-1:0]);
        dst_r  <= STMT_W'(stmt_r);
        last_r <= 1'b1;
        ovf_r  <= 1'b0;
      end
      EMIT_PEND_MID: begin
        src_r  <= STMT_W'(pend_r);
        dst_r  <= STMT_W'(stmt_r);
        last_r <= 1'b0;
        ovf_r  <= 1'b0;
      end
      EMIT_PEND_LAST: begin
        src_r  <= STMT_W'(pend_r);
        dst_r  <= STMT_W'(stmt_r);
        last_r <= 1'b1;
        ovf_r  <= 1'b0;
      end
      default: begin
        src_r  <= src_r;
        dst_r  <= dst_r;
        last_r <= last_r;
        ovf_r  <= ovf_r;
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_edge_source    = src_r;
  assign out_edge_target    = dst_r;
  assign out_last_of_run    = last_r;
  assign out_queue_overflow = ovf_r;

  // Status for the controller
  always_comb begin
    stat.in_range   = in_range_r;
    stat.is_write   = wr_r;
    stat.cnt_full   = (cnt_cur >= CW'(QUEUE_DEPTH));
    stat.cnt_zero   = (cnt_cur == '0);
    stat.front_wr   = (rd_q[SW] == KIND_WRITE);
    stat.front_same = (rd_q[SW-1:0] == stmt_r);
    stat.ent_same   = (rd_q[SW-1:0] == stmt_r);
    stat.more       = (idx_r < cnt_cur);
    stat.pend_v     = pend_v_r;
    stat.out_free   = out_free;
  end

endmodule

// File: src/access_hazard_edge_tracker.sv
// Top level of the access hazard edge tracker: channels, controller and datapath.
//
// Takes one access item at a time (statement, resource, read/write) and returns
// dependence edges between statements. Every item is taken and then looked up;
// a read into an empty or full queue, a write to an empty queue and an
// out-of-range resource end after the lookup, and a read into a non-empty
// queue also needs a front step, as the queue front comes from a registered
// memory read. A write to a non-empty queue drains it: the drain reads one
// entry per cycle through the single read port of the queue memory while the
// output is not stalled, and one edge is held back so the final one can carry
// last_of_run. A result register sits on the output; a new result waits while
// it holds one not yet taken. Queue entries are never cleared; each resource's
// fill count carries a valid bit that reset clears, so no reset pass is needed.
`timescale 1ns / 1ps
module access_hazard_edge_tracker
  import ahet_pkg::*;
#(
  parameter int RESOURCES      = RESOURCES_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int STATEMENT_BITS = STATEMENT_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ahet_in_if.sink    in_ch,
  ahet_out_if.source out_ch
);

  ahet_cmd_t  cmd;
  ahet_stat_t stat;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  // Sequence each item
  ahet_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Queue storage and result register
  ahet_dpath #(
    .RESOURCES      (RESOURCES),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .STATEMENT_BITS (STATEMENT_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_statement_id    (in_ch.statement_id),
    .in_resource_index  (in_ch.resource_index),
    .in_is_write        (in_ch.is_write),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_edge_source    (out_ch.edge_source),
    .out_edge_target    (out_ch.edge_target),
    .out_last_of_run    (out_ch.last_of_run),
    .out_queue_overflow (out_ch.queue_overflow),
    .cmd                (cmd),
    .stat               (stat)
  );

endmodule
